// File: hdl/mrle_pkg.sv
`default_nettype none

package mrle_pkg;

  // Sample and average width (signed Q8.8 at the default of 16)
  localparam int TempWidth   = 16;
  localparam int StepWidth   = 15;
  localparam int WeightWidth = 9;
  localparam int CfgWidth    = (StepWidth > WeightWidth) ? StepWidth : WeightWidth;
  localparam int CfgIdxWidth = 1;

  // Full blend weight, one in 1/256 units
  localparam int WeightOne = 256;

  // Difference and clamp width: room for temp +/- step without overflow
  localparam int DiffBase  = (TempWidth > StepWidth + 1) ? TempWidth : StepWidth + 1;
  localparam int DiffWidth = DiffBase + 2;
  // Blend sum: two products of temp by a 10-bit signed weight, plus carry
  localparam int ProdWidth = TempWidth + WeightWidth + 1;
  localparam int SumWidth  = ProdWidth + 1;
  localparam int WideWidth = (SumWidth > DiffWidth) ? SumWidth : DiffWidth;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgStepLimit   = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgBlendWeight = 1'd1;

  // Reset values of the configuration registers
  localparam logic [StepWidth-1:0]   StepLimitReset   = StepWidth'(128);
  localparam logic [WeightWidth-1:0] BlendWeightReset = WeightWidth'(64);

  // Window result handed to the smoothing stage
  typedef struct packed {
    logic                        pass;
    logic signed [TempWidth-1:0] median;
  } window_t;

  // Saturate a wide signed value to the sample range
  function automatic logic signed [TempWidth-1:0] sat_temp(
    input logic signed [WideWidth-1:0] v
  );
    logic signed [WideWidth-1:0] hi;
    logic signed [WideWidth-1:0] lo;
    hi = {{(WideWidth - TempWidth + 1){1'b0}}, {(TempWidth - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_temp = hi[TempWidth-1:0];
    end else if (v < lo) begin
      sat_temp = lo[TempWidth-1:0];
    end else begin
      sat_temp = v[TempWidth-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/mrle_window.sv
`default_nettype none

module mrle_window (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic signed [mrle_pkg::TempWidth-1:0] sample_i,
  output mrle_pkg::window_t                          win_o
);

  logic signed [mrle_pkg::TempWidth-1:0] w1_q;
  logic signed [mrle_pkg::TempWidth-1:0] w2_q;
  logic [1:0]                            fill_q;
  logic [1:0]                            fill_d;

  function automatic logic signed [mrle_pkg::TempWidth-1:0] middle_of(
    input logic signed [mrle_pkg::TempWidth-1:0] a,
    input logic signed [mrle_pkg::TempWidth-1:0] b,
    input logic signed [mrle_pkg::TempWidth-1:0] c
  );
    if (a > b) begin
      if (b > c) begin
        middle_of = b;
      end else if (a > c) begin
        middle_of = c;
      end else begin
        middle_of = a;
      end
    end else if (a > c) begin
      middle_of = a;
    end else if (b > c) begin
      middle_of = c;
    end else begin
      middle_of = b;
    end
  endfunction

  // Pass raw samples until two are stored; take the median from then on
  always_comb begin
    win_o.pass   = (fill_q < 2'd2);
    win_o.median = middle_of(w1_q, w2_q, sample_i);
  end

  // Count stored samples, hold at three
  always_comb begin
    fill_d = fill_q;
    if (adv_i && (fill_q != 2'd3)) begin
      fill_d = fill_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Shift the window on each processed request
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w1_q <= w2_q;
      w2_q <= sample_i;
    end
  end

  // A median request always leaves a full window behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !win_o.pass |=> fill_q == 2'd3)
    else $error("window: median taken before the window filled");

endmodule

`default_nettype wire

// File: hdl/mrle_smooth.sv
`default_nettype none

module mrle_smooth (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    adv_i,
  input  wire logic signed [mrle_pkg::TempWidth-1:0]   sample_i,
  input  wire mrle_pkg::window_t                       win_i,
  input  wire logic [mrle_pkg::StepWidth-1:0]          step_limit_i,
  input  wire logic [mrle_pkg::WeightWidth-1:0]        blend_weight_i,
  output logic signed [mrle_pkg::TempWidth-1:0]        filtered_o,
  output logic                                         stable_o
);

  localparam int Dw = mrle_pkg::DiffWidth;
  localparam int Pw = mrle_pkg::ProdWidth;
  localparam int Sw = mrle_pkg::SumWidth;
  localparam int Ww = mrle_pkg::WideWidth;
  localparam int Tw = mrle_pkg::TempWidth;
  localparam int Bw = mrle_pkg::WeightWidth;

  logic                 seeded_q;
  logic                 seeded_d;
  logic signed [Tw-1:0] avg_q;
  logic signed [Tw-1:0] avg_d;

  logic signed [Dw-1:0] diff;
  logic signed [Dw-1:0] step_s;
  logic signed [Dw-1:0] clamp_w;
  logic signed [Tw-1:0] clamped;
  logic [Bw-1:0]        weight;
  logic signed [Bw:0]   wt_new;
  logic signed [Bw:0]   wt_old;
  logic signed [Pw-1:0] prod_new;
  logic signed [Pw-1:0] prod_old;
  logic signed [Sw-1:0] blend_sum;
  logic signed [Sw-1:0] blend_shr;
  logic signed [Tw-1:0] blended;

  // Clamp the median to within the step limit of the average
  always_comb begin
    step_s = Dw'($signed({1'b0, step_limit_i}));
    diff   = Dw'(win_i.median) - Dw'(avg_q);
    if (diff > step_s) begin
      clamp_w = Dw'(avg_q) + step_s;
    end else if (diff < -step_s) begin
      clamp_w = Dw'(avg_q) - step_s;
    end else begin
      clamp_w = Dw'(win_i.median);
    end
    clamped = mrle_pkg::sat_temp(Ww'(clamp_w));
  end

  // Blend into the average, floor by the arithmetic shift
  always_comb begin
    weight    = (blend_weight_i > Bw'(mrle_pkg::WeightOne)) ?
                Bw'(mrle_pkg::WeightOne) : blend_weight_i;
    wt_new    = $signed({1'b0, weight});
    wt_old    = (Bw + 1)'(mrle_pkg::WeightOne) - wt_new;
    prod_new  = Pw'(clamped) * Pw'(wt_new);
    prod_old  = Pw'(avg_q) * Pw'(wt_old);
    blend_sum = Sw'(prod_new) + Sw'(prod_old);
    blend_shr = blend_sum >>> 8;
    blended   = mrle_pkg::sat_temp(Ww'(blend_shr));
  end

  // Select the result and the next average
  always_comb begin
    seeded_d   = seeded_q;
    avg_d      = avg_q;
    filtered_o = sample_i;
    stable_o   = seeded_q;
    if (!win_i.pass) begin
      if (!seeded_q) begin
        avg_d = win_i.median;
      end else begin
        avg_d = blended;
      end
      seeded_d   = 1'b1;
      filtered_o = avg_d;
      stable_o   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
      avg_q    <= '0;
    end else if (adv_i) begin
      seeded_q <= seeded_d;
      avg_q    <= avg_d;
    end
  end

  // Once seeded, the average stays seeded until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |=> seeded_q)
    else $error("smooth: seeded flag dropped");

  // A median request seeds the average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !win_i.pass |=> seeded_q)
    else $error("smooth: median request left the average unseeded");

endmodule

`default_nettype wire

// File: hdl/median_rate_limited_ema_filter_core.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    sample_i
// out       output     out_valid_o / out_stall_i  filtered_o, stable_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One request per cycle unless the output stalls, set by the average feedback:
// clamp and blend are combinational. Requests pass the input then output register.
// Reset clears the fill count, the seeded flag, the average and both valid flags.
// A stalled result holds the output register; the input register accepts while
// it is empty or while its request moves into the output register.

module median_rate_limited_ema_filter_core (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output logic                                          in_stall_o,
  input  wire logic signed [mrle_pkg::TempWidth-1:0]    sample_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic signed [mrle_pkg::TempWidth-1:0]         filtered_o,
  output logic                                          stable_o,
  input  wire logic                                     cfg_we_i,
  input  wire logic [mrle_pkg::CfgIdxWidth-1:0]         cfg_idx_i,
  input  wire logic [mrle_pkg::CfgWidth-1:0]            cfg_data_i
);

  logic [mrle_pkg::StepWidth-1:0]        step_limit_q;
  logic [mrle_pkg::WeightWidth-1:0]      blend_weight_q;

  logic                                  s1_valid_q;
  logic signed [mrle_pkg::TempWidth-1:0] sample_q;
  logic                                  out_valid_q;
  logic signed [mrle_pkg::TempWidth-1:0] filtered_q;
  logic                                  stable_q;

  logic                                  s2_ready;
  logic                                  adv;
  logic                                  in_accept;
  mrle_pkg::window_t                     win;
  logic signed [mrle_pkg::TempWidth-1:0] filtered_d;
  logic                                  stable_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q   <= mrle_pkg::StepLimitReset;
      blend_weight_q <= mrle_pkg::BlendWeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrle_pkg::CfgStepLimit: begin
          step_limit_q <= cfg_data_i[mrle_pkg::StepWidth-1:0];
        end
        mrle_pkg::CfgBlendWeight: begin
          blend_weight_q <= cfg_data_i[mrle_pkg::WeightWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Advance when the output register is free or being taken
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
  end

  mrle_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (sample_q),
    .win_o    (win)
  );

  mrle_smooth u_smooth (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .sample_i       (sample_q),
    .win_i          (win),
    .step_limit_i   (step_limit_q),
    .blend_weight_i (blend_weight_q),
    .filtered_o     (filtered_d),
    .stable_o       (stable_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      filtered_q <= filtered_d;
      stable_q   <= stable_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign stable_o    = stable_q;

  // Stall the input only when both registers hold a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("core: input stalled with a free stage");

  // A held request in the input register keeps its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(sample_q))
    else $error("core: held request lost or changed");

endmodule

`default_nettype wire
